>>> rtl/cssf_pkg.sv
// ----------------------------------------------------------------------------
// cssf_pkg: shared types and constants of the caseless substring field filter
// Holds the front-to-back token, queue status, register indexes, ASCII codes
// and the byte folding and classification helpers.
// ----------------------------------------------------------------------------
package cssf_pkg;

   localparam int CSR_DATA_W  = 64;
   localparam int CSR_INDEX_W = 2;
   localparam int LEN_W       = 5;
   localparam int COUNT_W     = 5;
   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   localparam logic [7:0] CHAR_UPPER_A  = 8'h41;
   localparam logic [7:0] CHAR_UPPER_Z  = 8'h5A;
   localparam logic [7:0] CHAR_LOWER_A  = 8'h61;
   localparam logic [7:0] CHAR_LBRACE   = 8'h7B;
   localparam logic [7:0] CHAR_LBRACKET = 8'h5B;
   localparam logic [7:0] CHAR_QUOTE    = 8'h22;
   localparam logic [7:0] CHAR_RBRACE   = 8'h7D;
   localparam logic [7:0] CHAR_RBRACKET = 8'h5D;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_NEEDLE_LENGTH = 2'd0,
      CSR_NEEDLE_LOW    = 2'd1,
      CSR_NEEDLE_HIGH   = 2'd2
   } csr_index_type;

   // Classified byte handed from the front to the back.
   typedef struct packed {
      logic has_byte;
      logic field_start;
      logic record_end;
      logic hit;          // needle ends at this byte
      logic first_pos;    // byte is the first of its field
      logic second_pos;   // byte is the second of its field
      logic hold_open;    // first byte opens a possible raw dump
      logic skip_field;   // second byte confirms a raw dump
      logic needle_empty;
   } token_type;

   typedef struct packed {
      logic full;
      logic empty;
   } qstat_type;

   function automatic logic [7:0] fold(input logic [7:0] c);
      logic [7:0] r;
      r = c;
      if (c >= CHAR_UPPER_A && c <= CHAR_UPPER_Z) begin
         r = c - CHAR_UPPER_A + CHAR_LOWER_A;
      end
      return r;
   endfunction

   function automatic logic is_open_bracket(input logic [7:0] c);
      return (c == CHAR_LBRACE) || (c == CHAR_LBRACKET);
   endfunction

   function automatic logic is_dump_second(input logic [7:0] c);
      return (c == CHAR_QUOTE) || (c == CHAR_LBRACE) ||
             (c == CHAR_RBRACE) || (c == CHAR_RBRACKET);
   endfunction

endpackage

>>> rtl/cssf_front.sv
// ----------------------------------------------------------------------------
// cssf_front: needle registers, byte window and parallel needle compare
// Folds each byte, compares the window against the aligned needle and
// tags the word with its place in the field.
// ----------------------------------------------------------------------------
module cssf_front import cssf_pkg::*; #(
   parameter int NEEDLE_MAX = 16
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   csr_write_en,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_data,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  logic [7:0]             req_data_byte,
   input  logic                   req_has_byte,
   input  logic                   req_field_start,
   input  logic                   req_is_id_field,
   input  logic                   req_record_end,
   output logic                   tok_valid,
   input  logic                   tok_ready,
   output token_type              tok
);

   localparam int HIST = (NEEDLE_MAX > 1) ? NEEDLE_MAX - 1 : 1;

   logic [LEN_W-1:0]      needle_len_ff;
   logic [CSR_DATA_W-1:0] needle_low_ff;
   logic [CSR_DATA_W-1:0] needle_high_ff;
   logic [7:0]            hist_ff [HIST];
   logic [7:0]            hist_in [HIST];
   logic [COUNT_W-1:0]    count_ff, count_in;
   logic                  first_open_ff, first_open_in;

   logic [2*CSR_DATA_W-1:0] needle_all;
   logic [7:0]              needle_f [NEEDLE_MAX];
   logic [7:0]              aligned  [NEEDLE_MAX];
   logic [7:0]              win      [NEEDLE_MAX];
   logic [LEN_W-1:0]        used_len;
   logic [COUNT_W-1:0]      count_start;
   logic                    first_open_start;
   logic [7:0]              c;
   logic                    hit;
   logic                    accept;

   assign needle_all = {needle_high_ff, needle_low_ff};
   assign used_len   = (needle_len_ff > LEN_W'(NEEDLE_MAX)) ? LEN_W'(NEEDLE_MAX)
                                                              : needle_len_ff;
   assign c          = fold(req_data_byte);
   assign accept     = req_valid && tok_ready;
   assign req_ready  = tok_ready;
   assign tok_valid  = req_valid;

   assign count_start      = req_field_start ? '0 : count_ff;
   assign first_open_start = req_field_start ? 1'b0 : first_open_ff;

   // Align the needle so that position j of the window meets byte n-1-j.
   always_comb begin
      logic [LEN_W-1:0] k;
      for (int m = 0; m < NEEDLE_MAX; m++) begin
         needle_f[m] = fold(needle_all[8*m +: 8]);
      end
      for (int j = 0; j < NEEDLE_MAX; j++) begin
         k = used_len - LEN_W'(j) - LEN_W'(1);
         aligned[j] = '0;
         for (int m = 0; m < NEEDLE_MAX; m++) begin
            if (LEN_W'(m) == k) begin
               aligned[j] = needle_f[m];
            end
         end
      end
   end

   always_comb begin
      win[0] = c;
      for (int j = 1; j < NEEDLE_MAX; j++) begin
         win[j] = hist_ff[j-1];
      end
      hit = (used_len != '0) &&
            ({1'b0, count_start} + (COUNT_W+1)'(1) >= {1'b0, used_len});
      for (int j = 0; j < NEEDLE_MAX; j++) begin
         if (LEN_W'(j) < used_len && win[j] != aligned[j]) begin
            hit = 1'b0;
         end
      end
   end

   always_comb begin
      tok.has_byte     = req_has_byte;
      tok.field_start  = req_field_start;
      tok.record_end   = req_record_end;
      tok.hit          = hit;
      tok.first_pos    = (count_start == '0);
      tok.second_pos   = (count_start == COUNT_W'(1));
      tok.hold_open    = !req_is_id_field && is_open_bracket(req_data_byte);
      tok.skip_field   = !req_is_id_field && first_open_start &&
                         is_dump_second(req_data_byte);
      tok.needle_empty = (used_len == '0);
   end

   always_comb begin
      hist_in       = hist_ff;
      count_in      = count_start;
      first_open_in = first_open_start;
      if (req_has_byte) begin
         hist_in[0] = c;
         for (int k = 1; k < HIST; k++) begin
            hist_in[k] = hist_ff[k-1];
         end
         if (count_start != '1) begin
            count_in = count_start + COUNT_W'(1);
         end
         if (count_start == '0) begin
            first_open_in = is_open_bracket(req_data_byte);
         end
      end
      if (req_record_end) begin
         count_in      = '0;
         first_open_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         needle_len_ff  <= '0;
         needle_low_ff  <= '0;
         needle_high_ff <= '0;
         count_ff       <= '0;
         first_open_ff  <= 1'b0;
      end else begin
         if (csr_write_en) begin
            case (csr_index)
               CSR_NEEDLE_LENGTH: needle_len_ff  <= csr_data[LEN_W-1:0];
               CSR_NEEDLE_LOW:    needle_low_ff  <= csr_data;
               CSR_NEEDLE_HIGH:   needle_high_ff <= csr_data;
               default: ;
            endcase
         end
         if (accept) begin
            count_ff      <= count_in;
            first_open_ff <= first_open_in;
         end
      end
   end

   // Window bytes are only compared inside their own field; no reset needed.
   always_ff @(posedge clock) begin
      if (accept) begin
         hist_ff <= hist_in;
      end
   end

endmodule

>>> rtl/cssf_queue.sv
// ----------------------------------------------------------------------------
// cssf_queue: short token queue between front and back
// Lets the front keep taking words while the back waits on the result side.
// ----------------------------------------------------------------------------
module cssf_queue import cssf_pkg::*; (
   input  logic      clock,
   input  logic      reset,
   input  logic      in_valid,
   output logic      in_ready,
   input  token_type in_tok,
   output logic      out_valid,
   input  logic      out_ready,
   output token_type out_tok,
   output qstat_type status
);

   token_type          slot_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]  wr_ptr_ff, rd_ptr_ff;
   logic [QCNT_W-1:0]  count_ff;
   logic               push, pop;

   assign status.full  = (count_ff == QCNT_W'(QUEUE_DEPTH));
   assign status.empty = (count_ff == '0);
   assign in_ready     = !status.full;
   assign out_valid    = !status.empty;
   assign out_tok      = slot_ff[rd_ptr_ff];
   assign push         = in_valid && in_ready;
   assign pop          = out_valid && out_ready;

   function automatic logic [QPTR_W-1:0] bump(input logic [QPTR_W-1:0] p);
      return (p == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + QPTR_W'(1);
   endfunction

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= bump(wr_ptr_ff);
         end
         if (pop) begin
            rd_ptr_ff <= bump(rd_ptr_ff);
         end
         if (push && !pop) begin
            count_ff <= count_ff + QCNT_W'(1);
         end else if (pop && !push) begin
            count_ff <= count_ff - QCNT_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= in_tok;
      end
   end

endmodule

>>> rtl/cssf_back.sv
// ----------------------------------------------------------------------------
// cssf_back: field and record bookkeeping and result register
// Applies the raw dump rule, commits matches and emits one word per record.
// ----------------------------------------------------------------------------
module cssf_back import cssf_pkg::*; (
   input  logic      clock,
   input  logic      reset,
   input  logic      tok_valid,
   output logic      tok_ready,
   input  token_type tok,
   output logic      pop,
   output logic      rsp_valid,
   input  logic      rsp_ready,
   output logic      rsp_record_matches
);

   logic pending_ff, pending_in;
   logic ignored_ff, ignored_in;
   logic matched_ff, matched_in;
   logic result;
   logic rsp_valid_ff, rsp_matches_ff;

   assign tok_ready          = !tok.record_end || !rsp_valid_ff || rsp_ready;
   assign pop                = tok_valid && tok_ready;
   assign rsp_valid          = rsp_valid_ff;
   assign rsp_record_matches = rsp_matches_ff;

   always_comb begin
      pending_in = pending_ff;
      ignored_in = ignored_ff;
      matched_in = matched_ff;
      result     = 1'b0;
      // close the previous field
      if (tok.field_start) begin
         matched_in = matched_in || pending_in;
         pending_in = 1'b0;
         ignored_in = 1'b0;
      end
      if (tok.has_byte) begin
         if (tok.first_pos) begin
            if (tok.hit) begin
               if (tok.hold_open) begin
                  pending_in = 1'b1;
               end else begin
                  matched_in = 1'b1;
               end
            end
         end else if (tok.second_pos) begin
            if (tok.skip_field) begin
               ignored_in = 1'b1;
            end else if (pending_in || tok.hit) begin
               matched_in = 1'b1;
            end
            pending_in = 1'b0;
         end else if (tok.hit && !ignored_in) begin
            matched_in = 1'b1;
         end
      end
      if (tok.record_end) begin
         result     = matched_in || pending_in || tok.needle_empty;
         matched_in = 1'b0;
         pending_in = 1'b0;
         ignored_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pending_ff   <= 1'b0;
         ignored_ff   <= 1'b0;
         matched_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (pop) begin
            pending_ff <= pending_in;
            ignored_ff <= ignored_in;
            matched_ff <= matched_in;
         end
         if (pop && tok.record_end) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (pop && tok.record_end) begin
         rsp_matches_ff <= result;
      end
   end

endmodule

>>> rtl/caseless_substring_field_filter.sv
// Result path: a record's result word passes the queue slot and then the result register
//   after its last word is accepted; a result-side stall can hold it in the queue.
// Throughput: one byte word per cycle; the needle compare over all window positions
//   is parallel in the front. The two-entry queue absorbs short result-side stalls;
//   a record end waiting on a held result stalls the back, then the input once full.
// Reset: synchronous, active high; clears the needle registers, field and record
//   state, the queue and the result valid flag.
// ----------------------------------------------------------------------------
// caseless_substring_field_filter: case-folded needle search over record fields
// Front folds and compares, the queue decouples, the back tracks fields and
// records and drives one result word per record.
// ----------------------------------------------------------------------------
module caseless_substring_field_filter import cssf_pkg::*; #(
   parameter int NEEDLE_MAX = 16
) (
   input  logic                   clock,
   input  logic                   reset,
   // configuration writes
   input  logic                   csr_write_en,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_data,
   // byte words in
   input  logic                   req_valid,
   output logic                   req_ready,
   input  logic [7:0]             req_data_byte,
   input  logic                   req_has_byte,
   input  logic                   req_field_start,
   input  logic                   req_is_id_field,
   input  logic                   req_record_end,
   // result words out
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output logic                   rsp_record_matches
);

   // front to queue
   logic      f_valid, f_ready;
   token_type f_tok;
   // queue to back
   logic      b_valid, b_ready;
   token_type b_tok;
   qstat_type q_status;
   logic      b_pop;

   // Front: hold needle, advance byte window, classify each word.
   cssf_front #(
      .NEEDLE_MAX(NEEDLE_MAX)
   ) u_front (
      .clock          (clock),
      .reset          (reset),
      .csr_write_en   (csr_write_en),
      .csr_index      (csr_index),
      .csr_data       (csr_data),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_data_byte  (req_data_byte),
      .req_has_byte   (req_has_byte),
      .req_field_start(req_field_start),
      .req_is_id_field(req_is_id_field),
      .req_record_end (req_record_end),
      .tok_valid      (f_valid),
      .tok_ready      (f_ready),
      .tok            (f_tok)
   );

   // Queue: buffer classified words while the back waits on the result side.
   cssf_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .in_valid (f_valid),
      .in_ready (f_ready),
      .in_tok   (f_tok),
      .out_valid(b_valid),
      .out_ready(b_ready),
      .out_tok  (b_tok),
      .status   (q_status)
   );

   // Back: commit or drop matches per field, emit one word per record.
   cssf_back u_back (
      .clock             (clock),
      .reset             (reset),
      .tok_valid         (b_valid),
      .tok_ready         (b_ready),
      .tok               (b_tok),
      .pop               (b_pop),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_record_matches(rsp_record_matches)
   );

   // An accepted word is in the queue on the next cycle.
   a_accept_lands: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !q_status.empty)
      else $error("accepted word missing from queue");

   // A new result only follows a record-closing word leaving the queue.
   a_result_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(b_pop && b_tok.record_end))
      else $error("result without record end");

   // The back never pops an empty queue.
   a_no_pop_empty: assert property (@(posedge clock) disable iff (reset)
      b_pop |-> !q_status.empty)
      else $error("pop from empty queue");

   // Full and empty are never flagged together.
   a_status_sane: assert property (@(posedge clock) disable iff (reset)
      !(q_status.full && q_status.empty))
      else $error("queue full and empty at once");

endmodule
